FILE: design/srrw_pkg.sv
package srrw_pkg;

  localparam int FILE_SIZE_W   = 24;
  localparam int TIMEOUT_W     = 16;
  localparam int TICK_W        = 16;
  localparam int START_W       = 24;
  localparam int LEN_W         = 11;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_RES       = 32;

  localparam int WIN_SLOTS_DEF = 32;
  localparam int SEG_BYTES_DEF = 1024;

  localparam int CMD_Q_DEPTH   = 2;
  localparam int RES_Q_DEPTH   = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(500);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = CFG_IDX_W'(1);

  // input actions
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_ARRIVAL = 1'b1;

  // result kinds
  localparam logic KIND_REQ     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic               action;
    logic [START_W-1:0] byte_start;
    logic [LEN_W-1:0]   seg_length;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [START_W-1:0] out_start;
    logic [LEN_W-1:0]   out_length;
    logic               last;
    logic               done_res;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               is_arrival;
    logic               in_file;
    logic [START_W-1:0] byte_start;
    logic [LEN_W-1:0]   seg_length;
  } cmd_t;

endpackage

FILE: design/selective_repeat_receive_window_top.sv
// Channel  Ports                        Direction  Moves
// input    in_push / in_full / in_data  in         tick or segment arrival
// result   out_pop / out_empty / out_data out      request or in-order delivery
// config   cfg_we / cfg_idx / cfg_wdata in         file size, timeout
//
// Back end, tick: walks the slots from the base up to the end of the window or file,
// one slot a cycle through the stamp RAM read port while the result queue has room.
// An arrival walks the ring from the base up to the end of the window or file, then
// makes D deliveries through the length RAM.
// rst_n is synchronous, active low; slot stamps and lengths are not cleared.
// A full result queue stalls the back end; the front queue keeps taking requests until it is full.
module selective_repeat_receive_window_top import srrw_pkg::*; #(
  parameter int WINDOW_SLOTS  = WIN_SLOTS_DEF,
  parameter int SEGMENT_BYTES = SEG_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  in_item_t             in_data,
  output logic                 in_full,
  input  logic                 out_pop,
  output out_item_t            out_data,
  output logic                 out_empty,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [FILE_SIZE_W-1:0] file_size_r;
  logic [TIMEOUT_W-1:0]   timeout_r;
  cmd_t                   cmd;
  logic                   cmd_empty;
  logic                   cmd_pop;
  out_item_t              res;
  logic                   res_push;
  logic                   res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FILE_SIZE: file_size_r <= cfg_wdata[FILE_SIZE_W-1:0];
        REG_TIMEOUT:   timeout_r   <= cfg_wdata[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srrw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .file_size (file_size_r),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop)
  );

  srrw_back #(
    .WINDOW_SLOTS  (WINDOW_SLOTS),
    .SEGMENT_BYTES (SEGMENT_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .file_size     (file_size_r),
    .timeout_ticks (timeout_r),
    .res           (res),
    .res_push      (res_push),
    .res_full      (res_full)
  );

  srrw_queue #(
    .DW    ($bits(out_item_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty)
  );

endmodule

FILE: design/srrw_queue.sv
module srrw_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] PTR_LAST = IW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [DW-1:0] mem_r [DEPTH];
  logic [IW-1:0] wr_ptr_r;
  logic [IW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push_ok;
  logic          pop_ok;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/srrw_front.sv
module srrw_front import srrw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  in_item_t               in_data,
  output logic                   in_full,
  input  logic [FILE_SIZE_W-1:0] file_size,
  output cmd_t                   cmd,
  output logic                   cmd_empty,
  input  logic                   cmd_pop
);

  cmd_t cmd_in;

  // an arrival at or past the end of the file can never match a slot
  always_comb begin
    cmd_in.is_arrival = (in_data.action == ACT_ARRIVAL);
    cmd_in.in_file    = (in_data.byte_start < file_size);
    cmd_in.byte_start = in_data.byte_start;
    cmd_in.seg_length = in_data.seg_length;
  end

  srrw_queue #(
    .DW    ($bits(cmd_t)),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd),
    .empty (cmd_empty)
  );

endmodule

FILE: design/srrw_back.sv
module srrw_back import srrw_pkg::*; #(
  parameter int WINDOW_SLOTS  = WIN_SLOTS_DEF,
  parameter int SEGMENT_BYTES = SEG_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  input  logic                   cmd_empty,
  output logic                   cmd_pop,
  input  logic [FILE_SIZE_W-1:0] file_size,
  input  logic [TIMEOUT_W-1:0]   timeout_ticks,
  output out_item_t              res,
  output logic                   res_push,
  input  logic                   res_full
);

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int CW     = $clog2(WINDOW_SLOTS + MAX_RES + 1);
  localparam int BYTE_W = FILE_SIZE_W + 1;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [CW-1:0]     W_CNT     = CW'(WINDOW_SLOTS);
  localparam logic [CW-1:0]     W_LAST    = CW'(WINDOW_SLOTS - 1);
  localparam logic [CW-1:0]     MAX_C     = CW'(MAX_RES);
  localparam logic [BYTE_W-1:0] SEG_B     = BYTE_W'(SEGMENT_BYTES);
  localparam logic [LEN_W-1:0]  SEG_L     = LEN_W'(SEGMENT_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_WALK,
    ST_EMIT,
    ST_FINISH
  } state_t;

  state_t              state_r;
  logic [BYTE_W-1:0]   base_byte_r;
  logic [SLOT_W-1:0]   base_slot_r;
  logic [TICK_W-1:0]   now_r;
  logic [WINDOW_SLOTS-1:0] recv_r;
  logic [WINDOW_SLOTS-1:0] reqd_r;

  // issue stage: slot pointer, byte address and count (also the arrival walk)
  logic [SLOT_W-1:0]   a_ptr_r;
  logic [BYTE_W-1:0]   a_addr_r;
  logic [CW-1:0]       a_cnt_r;

  // evaluate stage, lines up with the RAM read data
  logic                b_v_r;
  logic [SLOT_W-1:0]   b_ptr_r;
  logic [BYTE_W-1:0]   b_addr_r;

  logic [CW-1:0]       n_r;
  logic [CW-1:0]       k_r;
  logic                alive_r;
  logic [BYTE_W-1:0]   c_addr_r;
  logic [START_W-1:0]  arr_bs_r;
  logic [LEN_W-1:0]    arr_len_r;
  logic                arr_ok_r;
  logic                item_done_r;

  // one result held back until we know whether it is the last
  logic                hold_v_r;
  logic                hold_kind_r;
  logic [START_W-1:0]  hold_start_r;
  logic [LEN_W-1:0]    hold_len_r;

  logic [TICK_W-1:0]   stamp_mem [WINDOW_SLOTS];
  logic [LEN_W-1:0]    len_mem   [WINDOW_SLOTS];
  logic [TICK_W-1:0]   st_q_r;
  logic [LEN_W-1:0]    ln_q_r;

  logic [BYTE_W-1:0]   fs_ext;
  logic                a_in_file;
  logic                a_go;
  logic [TICK_W-1:0]   age;
  logic                need;
  logic                produce;
  logic                res_ok;
  logic                b_fire;
  logic                a_issue;
  logic [BYTE_W-1:0]   rem;
  logic [LEN_W-1:0]    req_len;
  logic                new_kind;
  logic [START_W-1:0]  new_start;
  logic [LEN_W-1:0]    new_len;
  logic                match;
  logic                extend;
  logic                walk_end;
  logic [BYTE_W-1:0]   c_addr_step;
  logic                fin_push;
  logic [SLOT_W-1:0]   a_ptr_inc;
  logic [SLOT_W-1:0]   base_slot_inc;
  logic                st_we;
  logic                len_we;

  always_comb begin
    fs_ext        = {1'b0, file_size};
    a_in_file     = (a_addr_r < fs_ext);
    a_ptr_inc     = (a_ptr_r == SLOT_LAST) ? '0 : a_ptr_r + 1'b1;
    base_slot_inc = (base_slot_r == SLOT_LAST) ? '0 : base_slot_r + 1'b1;

    a_go = ((state_r == ST_TICK) && (a_cnt_r != W_CNT) && a_in_file) ||
           ((state_r == ST_EMIT) && (a_cnt_r != k_r));

    // wraps like the tick counter
    age  = now_r - st_q_r;
    need = !recv_r[b_ptr_r] && (!reqd_r[b_ptr_r] || (age > timeout_ticks)) &&
           (n_r < MAX_C);

    produce = b_v_r && (((state_r == ST_TICK) && need) || (state_r == ST_EMIT));
    res_ok  = !hold_v_r || !res_full;
    b_fire  = b_v_r && (!produce || res_ok);
    a_issue = a_go && (!b_v_r || b_fire);

    // request length clipped at the end of the file
    rem     = fs_ext - b_addr_r;
    req_len = (rem < SEG_B) ? rem[LEN_W-1:0] : SEG_L;

    if (state_r == ST_EMIT) begin
      new_kind  = KIND_DELIVER;
      new_start = base_byte_r[START_W-1:0];
      new_len   = ln_q_r;
    end else begin
      new_kind  = KIND_REQ;
      new_start = b_addr_r[START_W-1:0];
      new_len   = req_len;
    end

    // arrival walk: mark the matching slot and measure the in-order run
    match       = arr_ok_r && (a_addr_r == {1'b0, arr_bs_r});
    extend      = alive_r && a_in_file && (recv_r[a_ptr_r] || match) && (k_r < MAX_C);
    walk_end    = (a_cnt_r == W_LAST) || !a_in_file;
    c_addr_step = extend ? c_addr_r + SEG_B : c_addr_r;

    fin_push = (state_r == ST_FINISH) && hold_v_r && !res_full;
    res_push = (produce && b_fire && hold_v_r) || fin_push;
    cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;

    st_we  = produce && b_fire && (state_r == ST_TICK);
    len_we = (state_r == ST_WALK) && match;

    res.kind       = hold_kind_r;
    res.out_start  = hold_start_r;
    res.out_length = hold_len_r;
    res.last       = (state_r == ST_FINISH);
    res.done_res   = item_done_r;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stamp_mem[b_ptr_r] <= now_r;
    end
    if (a_issue && (state_r == ST_TICK)) begin
      st_q_r <= stamp_mem[a_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[a_ptr_r] <= arr_len_r;
    end
    if (a_issue && (state_r == ST_EMIT)) begin
      ln_q_r <= len_mem[a_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_byte_r <= '0;
      base_slot_r <= '0;
      now_r       <= '0;
      recv_r      <= '0;
      reqd_r      <= '0;
      a_cnt_r     <= '0;
      b_v_r       <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      alive_r     <= 1'b0;
      hold_v_r    <= 1'b0;
      item_done_r <= 1'b0;
    end else begin
      if (produce && b_fire) begin
        hold_v_r     <= 1'b1;
        hold_kind_r  <= new_kind;
        hold_start_r <= new_start;
        hold_len_r   <= new_len;
      end else if (fin_push) begin
        hold_v_r <= 1'b0;
      end

      if (a_issue) begin
        b_v_r    <= 1'b1;
        b_ptr_r  <= a_ptr_r;
        b_addr_r <= a_addr_r;
      end else if (b_fire) begin
        b_v_r <= 1'b0;
      end

      if (st_we) begin
        reqd_r[b_ptr_r] <= 1'b1;
        n_r             <= n_r + 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            a_ptr_r  <= base_slot_r;
            a_addr_r <= base_byte_r;
            a_cnt_r  <= '0;
            n_r      <= '0;
            k_r      <= '0;
            if (cmd.is_arrival) begin
              arr_bs_r  <= cmd.byte_start;
              arr_len_r <= cmd.seg_length;
              arr_ok_r  <= cmd.in_file;
              alive_r   <= 1'b1;
              c_addr_r  <= base_byte_r;
              state_r   <= ST_WALK;
            end else begin
              now_r       <= now_r + 1'b1;
              item_done_r <= (base_byte_r >= fs_ext);
              state_r     <= ST_TICK;
            end
          end
        end
        ST_WALK: begin
          if (match) begin
            recv_r[a_ptr_r] <= 1'b1;
          end
          if (extend) begin
            k_r <= k_r + 1'b1;
          end else begin
            alive_r <= 1'b0;
          end
          c_addr_r <= c_addr_step;
          if (walk_end) begin
            item_done_r <= (c_addr_step >= fs_ext);
            a_ptr_r     <= base_slot_r;
            a_cnt_r     <= '0;
            state_r     <= ST_EMIT;
          end else begin
            a_ptr_r  <= a_ptr_inc;
            a_addr_r <= a_addr_r + SEG_B;
            a_cnt_r  <= a_cnt_r + 1'b1;
          end
        end
        ST_TICK: begin
          if (a_issue) begin
            a_ptr_r  <= a_ptr_inc;
            a_addr_r <= a_addr_r + SEG_B;
            a_cnt_r  <= a_cnt_r + 1'b1;
          end
          if (!a_go && !b_v_r) begin
            state_r <= ST_FINISH;
          end
        end
        ST_EMIT: begin
          if (a_issue) begin
            a_ptr_r <= a_ptr_inc;
            a_cnt_r <= a_cnt_r + 1'b1;
          end
          // the evaluate stage always delivers the slot at the base
          if (b_fire) begin
            recv_r[base_slot_r] <= 1'b0;
            reqd_r[base_slot_r] <= 1'b0;
            base_slot_r         <= base_slot_inc;
            base_byte_r         <= base_byte_r + SEG_B;
          end
          if (!a_go && !b_v_r) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!hold_v_r || !res_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (k_r <= a_cnt_r))
    else $error("in-order run longer than the slots walked");

  a_base_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && b_fire) |=> (base_byte_r == $past(base_byte_r) + SEG_B))
    else $error("window base did not advance by one segment");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!hold_v_r && !b_v_r))
    else $error("result or slot still in flight while idle");
`endif

endmodule
